// File: hw/rtl/stack_expression_evaluator_defines.svh
// Assertion macros used by the stack expression evaluator top level.
`ifndef STACK_EXPRESSION_EVALUATOR_DEFINES_SVH
`define STACK_EXPRESSION_EVALUATOR_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SEE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SEE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/see_pkg.sv
// Shared types, opcodes and constants of the stack expression evaluator.
package see_pkg;

    localparam int unsigned STACK_DEPTH_DEF = 16;
    localparam int unsigned DATA_W          = 32;
    localparam int unsigned OP_W            = 8;
    localparam int unsigned DEPTH_OUT_W     = 5;
    localparam int unsigned DIV_STEPS       = DATA_W;

    typedef logic [DATA_W-1:0] t_word;
    typedef logic [OP_W-1:0]   t_op;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_DIV0  = 2'd1,
        ERR_OVER  = 2'd2,
        ERR_UNDER = 2'd3
    } t_err;

    localparam t_op OP_RETURN = 8'h0B;
    localparam t_op OP_EQ     = 8'h12;
    localparam t_op OP_NE     = 8'h13;
    localparam t_op OP_LT_BT  = 8'h14;
    localparam t_op OP_LT_TB  = 8'h15;
    localparam t_op OP_GE_TB  = 8'h16;
    localparam t_op OP_GE_BT  = 8'h17;
    localparam t_op OP_ZERO   = 8'h18;
    localparam t_op OP_NOT    = 8'h19;
    localparam t_op OP_LAND   = 8'h1A;
    localparam t_op OP_OR_A   = 8'h1B;
    localparam t_op OP_ADD    = 8'h1C;
    localparam t_op OP_SUB    = 8'h1D;
    localparam t_op OP_NEG    = 8'h1E;
    localparam t_op OP_XOR    = 8'h1F;
    localparam t_op OP_AND    = 8'h20;
    localparam t_op OP_OR_B   = 8'h21;
    localparam t_op OP_DIV    = 8'h22;
    localparam t_op OP_MUL    = 8'h23;
    localparam t_op OP_MOD    = 8'h24;

    localparam t_op OP_BIN_LO = OP_EQ;
    localparam t_op OP_BIN_HI = OP_MOD;

    typedef struct packed {
        logic  start;
        t_word dividend;
        t_word divisor;
    } t_div_req;

    typedef struct packed {
        logic  done;
        t_word quotient;
        t_word remainder;
    } t_div_rsp;

endpackage

// File: hw/rtl/see_in_if.sv
// Input channel: one item pushes a value or applies an operator byte.
interface see_in_if;
    import see_pkg::*;

    logic  valid;
    logic  ready;
    logic  mode;
    t_op   opcode;
    t_word push_value;

    modport source (output valid, output mode, output opcode, output push_value, input ready);
    modport sink   (input valid, input mode, input opcode, input push_value, output ready);
endinterface

// File: hw/rtl/see_out_if.sv
// Output channel: one result item per accepted input item.
interface see_out_if;
    import see_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   returned;
    t_word                  return_value;
    logic [1:0]             error_code;
    logic [DEPTH_OUT_W-1:0] stack_depth;

    modport source (output valid, output returned, output return_value, output error_code,
                    output stack_depth, input ready);
    modport sink   (input valid, input returned, input return_value, input error_code,
                    input stack_depth, output ready);
endinterface

// File: hw/rtl/see_div.sv
// Iterative signed divider: one quotient bit per cycle, then a sign fix-up step.
module see_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  see_pkg::t_div_req i_req,
    output see_pkg::t_div_rsp o_rsp
);
    import see_pkg::*;

    localparam int unsigned CNT_W = $clog2(DIV_STEPS + 1);

    function automatic t_word mag(input t_word v);
        mag = v[DATA_W-1] ? (t_word'(0) - v) : v;
    endfunction

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_word            r_rem, n_rem;
    t_word            r_quo, n_quo;
    t_word            r_dvs, n_dvs;
    logic             r_neg_q, n_neg_q;
    logic             r_neg_r, n_neg_r;
    t_word            r_q_out, n_q_out;
    t_word            r_r_out, n_r_out;
    t_word            shifted;
    logic [DATA_W:0]  diff;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_dvs   = r_dvs;
        n_neg_q = r_neg_q;
        n_neg_r = r_neg_r;
        n_q_out = r_q_out;
        n_r_out = r_r_out;
        // bring down the next dividend bit and try the subtraction
        shifted = {r_rem[DATA_W-2:0], r_quo[DATA_W-1]};
        diff    = {1'b0, shifted} - {1'b0, r_dvs};
        if (i_req.start) begin
            n_busy  = 1'b1;
            n_cnt   = '0;
            n_rem   = '0;
            n_quo   = mag(i_req.dividend);
            n_dvs   = mag(i_req.divisor);
            n_neg_q = i_req.dividend[DATA_W-1] ^ i_req.divisor[DATA_W-1];
            n_neg_r = i_req.dividend[DATA_W-1];
        end else if (r_busy) begin
            if (r_cnt == CNT_W'(DIV_STEPS)) begin
                // quotient truncates toward zero, remainder follows the dividend
                n_busy  = 1'b0;
                n_done  = 1'b1;
                n_q_out = r_neg_q ? (t_word'(0) - r_quo) : r_quo;
                n_r_out = r_neg_r ? (t_word'(0) - r_rem) : r_rem;
            end else begin
                n_cnt = r_cnt + CNT_W'(1);
                if (!diff[DATA_W]) begin
                    n_rem = diff[DATA_W-1:0];
                    n_quo = {r_quo[DATA_W-2:0], 1'b1};
                end else begin
                    n_rem = shifted;
                    n_quo = {r_quo[DATA_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_dvs   <= n_dvs;
        r_neg_q <= n_neg_q;
        r_neg_r <= n_neg_r;
        r_q_out <= n_q_out;
        r_r_out <= n_r_out;
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_q_out;
    assign o_rsp.remainder = r_r_out;

endmodule

// File: hw/rtl/stack_expression_evaluator.sv
// Stack expression evaluator top level: sequencer, value stack memory, ALU and divider.
// Path from input accept to result: push, pop and stack errors go straight to S_DONE; return
// reads the top (S_TOP); unary ops add a write-back (S_WB); binary ops and zero divisors add
// S_BELOW; divide and modulo add S_DIV, the shared divider's 32 one-bit steps and sign fix-up.
// One item in flight at a time; ready returns in the same cycle that the result registers.
// Synchronous active-low reset: one zero entry on the stack, no memory clearing pass.
`include "stack_expression_evaluator_defines.svh"

module stack_expression_evaluator #(
    parameter int unsigned STACK_DEPTH = see_pkg::STACK_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    see_in_if.sink    i_in,
    see_out_if.source o_out
);
    import see_pkg::*;

    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_FULL = CW'(STACK_DEPTH);

    // One-hot sequencer states
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_TOP   = 6'b000010,
        S_BELOW = 6'b000100,
        S_DIV   = 6'b001000,
        S_WB    = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    function automatic logic f_unary(input t_op op);
        f_unary = (op == OP_ZERO) || (op == OP_NOT) || (op == OP_NEG);
    endfunction

    function automatic logic f_binary(input t_op op);
        f_binary = (op >= OP_BIN_LO) && (op <= OP_BIN_HI) && !f_unary(op);
    endfunction

    t_state           r_state, n_state;
    logic [CW-1:0]    r_depth, n_depth;
    logic             r_bot_valid, n_bot_valid;
    t_op              r_op, n_op;
    t_word            r_t, n_t;
    t_word            r_res, n_res;
    t_err             r_err, n_err;
    logic             r_ret, n_ret;
    t_word            r_ret_val, n_ret_val;

    // Value stack memory with registered read
    t_word            r_stack [STACK_DEPTH];
    t_word            r_rd_data;
    logic             r_rd_zero;
    logic             mem_we, mem_re;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    t_word            mem_wdata;
    t_word            rd_val;

    // Output register
    logic                   r_out_valid, n_out_valid;
    logic                   r_o_returned, n_o_returned;
    t_word                  r_o_value, n_o_value;
    t_err                   r_o_err, n_o_err;
    logic [DEPTH_OUT_W-1:0] r_o_depth, n_o_depth;

    logic             in_acc;
    logic             in_unary, in_binary, in_return;
    logic             r_is_unary, r_is_binary, r_is_return, r_is_divmod;
    logic [AW-1:0]    top_idx, below_idx;
    t_word            alu, unary_res;
    t_div_req         div_req;
    t_div_rsp         div_rsp;

    see_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && (r_state == S_IDLE);

    assign in_unary    = f_unary(i_in.opcode);
    assign in_binary   = f_binary(i_in.opcode);
    assign in_return   = (i_in.opcode == OP_RETURN);
    assign r_is_unary  = f_unary(r_op);
    assign r_is_binary = f_binary(r_op);
    assign r_is_return = (r_op == OP_RETURN);
    assign r_is_divmod = (r_op == OP_DIV) || (r_op == OP_MOD);

    // Top and second entries; only used when the depth covers them
    assign top_idx   = AW'(r_depth - CW'(1));
    assign below_idx = AW'(r_depth - CW'(2));

    // An untouched bottom entry after reset or return reads as zero
    assign rd_val = r_rd_zero ? '0 : r_rd_data;

    // Unary ops on the top entry
    always_comb begin
        case (r_op)
            OP_ZERO: unary_res = t_word'(rd_val == '0);
            OP_NOT:  unary_res = ~rd_val;
            default: unary_res = t_word'(0) - rd_val;
        endcase
    end

    // Binary ops: B arrives from the memory, T was held from the previous read
    always_comb begin
        case (r_op)
            OP_EQ:   alu = t_word'(rd_val == r_t);
            OP_NE:   alu = t_word'(rd_val != r_t);
            OP_LT_BT: alu = t_word'($signed(rd_val) < $signed(r_t));
            OP_LT_TB: alu = t_word'($signed(r_t) < $signed(rd_val));
            OP_GE_TB: alu = t_word'($signed(r_t) >= $signed(rd_val));
            OP_GE_BT: alu = t_word'($signed(rd_val) >= $signed(r_t));
            OP_LAND: alu = t_word'((rd_val != '0) && (r_t != '0));
            OP_OR_A: alu = rd_val | r_t;
            OP_OR_B: alu = rd_val | r_t;
            OP_ADD:  alu = rd_val + r_t;
            OP_SUB:  alu = rd_val - r_t;
            OP_XOR:  alu = rd_val ^ r_t;
            OP_AND:  alu = rd_val & r_t;
            OP_MUL:  alu = rd_val * r_t;
            default: alu = rd_val;
        endcase
    end

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_depth      = r_depth;
        n_bot_valid  = r_bot_valid;
        n_op         = r_op;
        n_t          = r_t;
        n_res        = r_res;
        n_err        = r_err;
        n_ret        = r_ret;
        n_ret_val    = r_ret_val;
        mem_we       = 1'b0;
        mem_waddr    = top_idx;
        mem_wdata    = r_res;
        mem_re       = 1'b0;
        mem_raddr    = top_idx;
        div_req.start    = 1'b0;
        div_req.dividend = rd_val;
        div_req.divisor  = r_t;
        // drop the held result once taken
        n_out_valid  = r_out_valid && !o_out.ready;
        n_o_returned = r_o_returned;
        n_o_value    = r_o_value;
        n_o_err      = r_o_err;
        n_o_depth    = r_o_depth;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op      = i_in.opcode;
                    n_err     = ERR_OK;
                    n_ret     = 1'b0;
                    n_ret_val = '0;
                    n_state   = S_DONE;
                    if (!i_in.mode) begin
                        // push: write straight into the next free entry
                        if (r_depth >= DEPTH_FULL) begin
                            n_err = ERR_OVER;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = AW'(r_depth);
                            mem_wdata = i_in.push_value;
                            n_depth   = r_depth + CW'(1);
                        end
                    end else if (r_depth == '0) begin
                        n_err = ERR_UNDER;
                    end else if (in_binary && (r_depth < CW'(2))) begin
                        n_err = ERR_UNDER;
                    end else if (in_unary || in_binary || in_return) begin
                        mem_re  = 1'b1;
                        n_state = S_TOP;
                    end else begin
                        // pop-only opcode
                        n_depth = r_depth - CW'(1);
                    end
                end
            end
            S_TOP: begin
                n_t = rd_val;
                if (r_is_return) begin
                    // deliver the top entry and return the stack to its reset contents
                    n_ret       = 1'b1;
                    n_ret_val   = rd_val;
                    n_depth     = CW'(1);
                    n_bot_valid = 1'b0;
                    n_state     = S_DONE;
                end else if (r_is_unary) begin
                    n_res   = unary_res;
                    n_state = S_WB;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = below_idx;
                    n_state   = S_BELOW;
                end
            end
            S_BELOW: begin
                if (r_is_divmod) begin
                    if (r_t == '0) begin
                        n_err   = ERR_DIV0;
                        n_res   = '0;
                        n_state = S_WB;
                    end else begin
                        div_req.start = 1'b1;
                        n_state       = S_DIV;
                    end
                end else begin
                    n_res   = alu;
                    n_state = S_WB;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_res   = (r_op == OP_MOD) ? div_rsp.remainder : div_rsp.quotient;
                    n_state = S_WB;
                end
            end
            S_WB: begin
                // unary ops replace the top, binary ops replace the second and pop
                mem_we    = 1'b1;
                mem_waddr = r_is_binary ? below_idx : top_idx;
                mem_wdata = r_res;
                if (r_is_binary) begin
                    n_depth = r_depth - CW'(1);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                // hold here until the output register is free
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_o_returned = r_ret;
                    n_o_value    = r_ret_val;
                    n_o_err      = r_err;
                    n_o_depth    = DEPTH_OUT_W'(r_depth);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // any write to the bottom entry makes it real
        if (mem_we && (mem_waddr == '0)) begin
            n_bot_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= CW'(1);
            r_bot_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_bot_valid <= n_bot_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_t          <= n_t;
        r_res        <= n_res;
        r_err        <= n_err;
        r_ret        <= n_ret;
        r_ret_val    <= n_ret_val;
        r_o_returned <= n_o_returned;
        r_o_value    <= n_o_value;
        r_o_err      <= n_o_err;
        r_o_depth    <= n_o_depth;
    end

    // Stack memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_stack[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_stack[mem_raddr];
            r_rd_zero <= (mem_raddr == '0) && !r_bot_valid;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.returned     = r_o_returned;
    assign o_out.return_value = r_o_value;
    assign o_out.error_code   = r_o_err;
    assign o_out.stack_depth  = r_o_depth;

    `SEE_ASSERT_IMPL(a_depth_bound, i_clk, i_rst_n, 1'b1, r_depth <= DEPTH_FULL, "stack depth beyond capacity")
    `SEE_ASSERT_IMPL(a_div_done_waited, i_clk, i_rst_n, div_rsp.done, r_state == S_DIV, "divider finished outside its wait state")
    `SEE_ASSERT_NEXT(a_return_resets, i_clk, i_rst_n, (r_state == S_TOP) && r_is_return, (r_depth == CW'(1)) && !r_bot_valid, "return did not reset the stack")

endmodule

// File: verif/stack_expression_evaluator_tb.sv
// Self-checking testbench for the stack expression evaluator, with a shadow stack predictor.
`timescale 1ns / 1ps

module stack_expression_evaluator_tb;
    import see_pkg::*;

    localparam int unsigned DEPTH       = STACK_DEPTH_DEF;
    localparam int          ITEM_TARGET = 1900;
    localparam int          CYCLE_LIMIT = 600000;
    localparam int          IDLE_PCT    = 8;
    localparam int          HOLD_AT     = 400;
    localparam int          HOLD_CYCLES = 300;
    localparam int          QUIET_LO    = 700;
    localparam int          QUIET_HI    = 1000;
    localparam int          DRAIN_WAIT  = 60;

    // Opcodes outside the decoded set only pop; these two bound that set.
    localparam t_op OP_POP_LO = 8'h00;
    localparam t_op OP_POP_HI = 8'hFF;

    typedef struct packed {
        logic  mode;
        t_op   opcode;
        t_word push_value;
    } t_cmd;

    typedef struct packed {
        logic                   returned;
        t_word                  return_value;
        t_err                   error_code;
        logic [DEPTH_OUT_W-1:0] stack_depth;
    } t_answer;

    logic clk;
    logic rst_n;

    see_in_if  in_ch ();
    see_out_if out_ch ();

    stack_expression_evaluator i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_cmd    cmd_q[$];
    t_answer answer_q[$];

    // Shadow copy of the evaluation stack, advanced on every accepted item.
    t_word shadow_stack [DEPTH];
    int    shadow_depth;

    // Depth the stimulus expects to reach; steers the generator only.
    int planned_depth;

    int   items_taken;
    int   fail_count;
    int   cycle_count;
    int   hold_left;
    logic hold_done;
    logic in_took;
    logic quiet_stretch;

    assign quiet_stretch = (items_taken >= QUIET_LO) && (items_taken < QUIET_HI);

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void reset_shadow();
        for (int i = 0; i < DEPTH; i++) shadow_stack[i] = '0;
        shadow_depth = 1;
    endfunction

    // Apply one item to the shadow stack and return the answer it gives.
    function automatic t_answer evaluate_on_shadow(input t_cmd c);
        t_answer a;
        t_word   top, below, res, mag_b, mag_t, q;
        a.returned     = 1'b0;
        a.return_value = '0;
        a.error_code   = ERR_OK;
        if (c.mode == 1'b0) begin
            if (shadow_depth >= DEPTH) begin
                a.error_code = ERR_OVER;
            end else begin
                shadow_stack[shadow_depth] = c.push_value;
                shadow_depth++;
            end
        end else if (c.opcode == OP_RETURN) begin
            if (shadow_depth == 0) begin
                a.error_code = ERR_UNDER;
            end else begin
                a.returned     = 1'b1;
                a.return_value = shadow_stack[shadow_depth-1];
                reset_shadow();
            end
        end else if (c.opcode == OP_ZERO || c.opcode == OP_NOT || c.opcode == OP_NEG) begin
            if (shadow_depth == 0) begin
                a.error_code = ERR_UNDER;
            end else begin
                top = shadow_stack[shadow_depth-1];
                case (c.opcode)
                    OP_ZERO: top = (top == '0) ? 32'd1 : 32'd0;
                    OP_NOT:  top = ~top;
                    default: top = -top;
                endcase
                shadow_stack[shadow_depth-1] = top;
            end
        end else if (c.opcode >= OP_BIN_LO && c.opcode <= OP_BIN_HI) begin
            if (shadow_depth < 2) begin
                a.error_code = ERR_UNDER;
            end else begin
                top   = shadow_stack[shadow_depth-1];
                below = shadow_stack[shadow_depth-2];
                mag_b = below[DATA_W-1] ? -below : below;
                mag_t = top[DATA_W-1]   ? -top   : top;
                case (c.opcode)
                    OP_EQ:    res = {31'd0, below == top};
                    OP_NE:    res = {31'd0, below != top};
                    OP_LT_BT: res = {31'd0, $signed(below) < $signed(top)};
                    OP_LT_TB: res = {31'd0, $signed(top) < $signed(below)};
                    OP_GE_TB: res = {31'd0, $signed(top) >= $signed(below)};
                    OP_GE_BT: res = {31'd0, $signed(below) >= $signed(top)};
                    OP_LAND:  res = {31'd0, (below != '0) && (top != '0)};
                    OP_OR_A,
                    OP_OR_B:  res = below | top;
                    OP_ADD:   res = below + top;
                    OP_SUB:   res = below - top;
                    OP_XOR:   res = below ^ top;
                    OP_AND:   res = below & top;
                    OP_MUL:   res = below * top;
                    OP_DIV: begin
                        // Divide magnitudes, then fix the sign: truncates toward zero
                        // and wraps the most negative value over minus one.
                        if (top == '0) begin
                            a.error_code = ERR_DIV0;
                            res          = '0;
                        end else begin
                            q   = mag_b / mag_t;
                            res = (below[DATA_W-1] ^ top[DATA_W-1]) ? -q : q;
                        end
                    end
                    OP_MOD: begin
                        // Remainder follows the sign of the dividend.
                        if (top == '0) begin
                            a.error_code = ERR_DIV0;
                            res          = '0;
                        end else begin
                            q   = mag_b % mag_t;
                            res = below[DATA_W-1] ? -q : q;
                        end
                    end
                    default: res = below;
                endcase
                shadow_stack[shadow_depth-2] = res;
                shadow_depth--;
            end
        end else begin
            if (shadow_depth == 0) a.error_code = ERR_UNDER;
            else shadow_depth--;
        end
        a.stack_depth = shadow_depth[DEPTH_OUT_W-1:0];
        return a;
    endfunction

    function automatic t_word rand_word();
        t_word v;
        case ($urandom_range(0, 9))
            0: v = 32'h0000_0000;
            1: v = 32'h0000_0001;
            2: v = 32'hFFFF_FFFF;
            3: v = 32'h8000_0000;
            4: v = 32'h7FFF_FFFF;
            5: v = $urandom_range(0, 20);
            6: v = -t_word'($urandom_range(1, 20));
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Unused fields carry random bits so that every input bit toggles.
    function automatic t_cmd push_cmd(input t_word v);
        t_cmd c;
        c.mode       = 1'b0;
        c.opcode     = t_op'($urandom_range(0, 255));
        c.push_value = v;
        return c;
    endfunction

    function automatic t_cmd op_cmd(input t_op op);
        t_cmd c;
        c.mode       = 1'b1;
        c.opcode     = op;
        c.push_value = $urandom;
        return c;
    endfunction

    function automatic t_op pick_binary();
        t_op op;
        case ($urandom_range(0, 16))
            0:  op = OP_EQ;
            1:  op = OP_NE;
            2:  op = OP_LT_BT;
            3:  op = OP_LT_TB;
            4:  op = OP_GE_TB;
            5:  op = OP_GE_BT;
            6:  op = OP_LAND;
            7:  op = OP_OR_A;
            8:  op = OP_ADD;
            9:  op = OP_SUB;
            10: op = OP_XOR;
            11: op = OP_AND;
            12: op = OP_OR_B;
            13: op = OP_DIV;
            14: op = OP_MUL;
            15: op = OP_MOD;
            default: op = OP_DIV;
        endcase
        return op;
    endfunction

    function automatic t_op pick_unary();
        t_op op;
        case ($urandom_range(0, 2))
            0:       op = OP_ZERO;
            1:       op = OP_NOT;
            default: op = OP_NEG;
        endcase
        return op;
    endfunction

    function automatic t_op pick_pop_only();
        t_op op;
        op = t_op'($urandom_range(0, 255));
        while (op == OP_RETURN || (op >= OP_BIN_LO && op <= OP_BIN_HI))
            op = t_op'($urandom_range(0, 255));
        return op;
    endfunction

    // Queue an item and track the depth it leads to.
    function automatic void plan(input t_cmd c);
        cmd_q.push_back(c);
        if (c.mode == 1'b0) begin
            if (planned_depth < DEPTH) planned_depth++;
        end else if (c.opcode == OP_RETURN) begin
            if (planned_depth > 0) planned_depth = 1;
        end else if (c.opcode == OP_ZERO || c.opcode == OP_NOT || c.opcode == OP_NEG) begin
            planned_depth = planned_depth;
        end else if (c.opcode >= OP_BIN_LO && c.opcode <= OP_BIN_HI) begin
            if (planned_depth >= 2) planned_depth--;
        end else if (planned_depth > 0) begin
            planned_depth--;
        end
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch: expected 0x%08h, actual 0x%08h",
                     $time, name, want, got);
            fail_count++;
        end
    endtask

    // Stimulus: directed corner cases, then randomised expression traffic.
    initial begin
        int r;
        int burst;
        in_ch.valid      = 1'b0;
        in_ch.mode       = 1'b0;
        in_ch.opcode     = '0;
        in_ch.push_value = '0;
        out_ch.ready     = 1'b0;
        rst_n            = 1'b0;
        planned_depth    = 1;

        // Unary on the reset entry, then most negative over minus one.
        plan(op_cmd(OP_NEG));
        plan(push_cmd(32'h8000_0000));
        plan(push_cmd(32'hFFFF_FFFF));
        plan(op_cmd(OP_DIV));
        plan(push_cmd(32'hFFFF_FFFF));
        plan(op_cmd(OP_MOD));
        // Zero divisor on both divide and modulo.
        plan(push_cmd(32'h7FFF_FFFF));
        plan(push_cmd(32'h0000_0000));
        plan(op_cmd(OP_DIV));
        plan(push_cmd(32'h0000_0000));
        plan(op_cmd(OP_MOD));
        plan(push_cmd(32'h8000_0000));
        plan(op_cmd(OP_NOT));
        plan(op_cmd(OP_ZERO));
        plan(op_cmd(OP_RETURN));
        // Pop to empty, then underflow on every kind of operator.
        plan(op_cmd(OP_POP_LO));
        plan(op_cmd(OP_ZERO));
        plan(op_cmd(OP_ADD));
        plan(op_cmd(OP_RETURN));
        plan(op_cmd(OP_POP_HI));
        plan(push_cmd(32'hFFFF_FFFF));
        plan(push_cmd(32'h0000_0001));
        plan(op_cmd(OP_LT_BT));
        plan(op_cmd(OP_RETURN));

        // Mostly well-formed expressions, with overflow bursts and raw opcodes mixed in.
        while (cmd_q.size() < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (planned_depth < 2 && r < 60) begin
                plan(push_cmd(rand_word()));
            end else if (r < 36) begin
                plan(push_cmd(rand_word()));
            end else if (r < 62) begin
                plan(op_cmd(pick_binary()));
            end else if (r < 72) begin
                plan(op_cmd(pick_unary()));
            end else if (r < 79) begin
                plan(op_cmd(OP_RETURN));
            end else if (r < 86) begin
                plan(op_cmd(pick_pop_only()));
            end else if (r < 92) begin
                plan(op_cmd(t_op'($urandom_range(0, 255))));
            end else if (r < 94) begin
                // Fill to the top and push past it.
                burst = DEPTH - planned_depth + $urandom_range(1, 2);
                repeat (burst) plan(push_cmd(rand_word()));
            end else begin
                plan(push_cmd(rand_word()));
            end
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Drain: wait for every item to be taken and every answer to arrive.
        while (cmd_q.size() != 0 || in_ch.valid || answer_q.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Input driver: hold the item until taken, then advance or idle.
    always @(negedge clk) begin
        t_cmd nxt;
        logic give;
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_took) begin
            give = (cmd_q.size() != 0) &&
                   (quiet_stretch || $urandom_range(0, 99) >= IDLE_PCT);
            if (give) begin
                nxt               = cmd_q.pop_front();
                in_ch.mode       <= nxt.mode;
                in_ch.opcode     <= nxt.opcode;
                in_ch.push_value <= nxt.push_value;
                in_ch.valid      <= 1'b1;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Result acceptor: random back-pressure plus one long hold-off that stalls the input.
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else if (!hold_done && items_taken >= HOLD_AT) begin
            hold_done    <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= quiet_stretch || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Monitor: check each result against the oldest answer, then predict for a taken item.
    always @(posedge clk) begin
        t_answer want;
        t_cmd    taken;
        if (!rst_n) begin
            in_took      <= 1'b0;
            items_taken  <= 0;
            reset_shadow();
        end else begin
            in_took <= in_ch.valid && in_ch.ready;
            if (out_ch.valid && out_ch.ready) begin
                if (answer_q.size() == 0) begin
                    $display("%0t ns: result with no item pending: returned %0b value 0x%08h",
                             $time, out_ch.returned, out_ch.return_value);
                    fail_count++;
                end else begin
                    want = answer_q.pop_front();
                    check_field("returned", 32'(want.returned), 32'(out_ch.returned));
                    check_field("return_value", want.return_value, out_ch.return_value);
                    check_field("error_code", 32'(want.error_code), 32'(out_ch.error_code));
                    check_field("stack_depth", 32'(want.stack_depth), 32'(out_ch.stack_depth));
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                taken.mode       = in_ch.mode;
                taken.opcode     = in_ch.opcode;
                taken.push_value = in_ch.push_value;
                answer_q.push_back(evaluate_on_shadow(taken));
                items_taken <= items_taken + 1;
            end
        end
    end

    // Watchdog: drop out if the run stops making progress.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        fail_count  = 0;
        cycle_count = 0;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/see_pkg.sv
hw/rtl/see_in_if.sv
hw/rtl/see_out_if.sv
hw/rtl/see_div.sv
hw/rtl/stack_expression_evaluator.sv
verif/stack_expression_evaluator_tb.sv
